[hw/rtl/lbdg_pkg.sv]
// Shared types and constants for the load-based DVFS governor.
`timescale 1ns / 1ps
package lbdg_pkg;

    localparam int FREQ_W    = 22;
    localparam int TASK_W    = 8;
    localparam int FUNC_W    = 2;
    localparam int CFG_W     = 32;
    localparam int LOAD_W    = 7;
    localparam int PROD_W    = FREQ_W + LOAD_W;
    localparam int PC_W      = 5;

    localparam logic [FUNC_W-1:0] FUNC_IDLE_EXIT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LIMITS    = 2'd2;

    localparam logic [1:0] REG_MIN_SAMPLE = 2'd0;
    localparam logic [1:0] REG_FREQ_MIN   = 2'd1;
    localparam logic [1:0] REG_FREQ_MAX   = 2'd2;

    localparam logic [CFG_W-1:0]  MIN_SAMPLE_RST = 32'd50000;
    localparam logic [FREQ_W-1:0] FREQ_MIN_RST   = 22'd300000;
    localparam logic [FREQ_W-1:0] FREQ_MAX_RST   = 22'd1000000;

    localparam logic [LOAD_W-1:0] LOAD_FULL     = 7'd100;
    localparam logic [TASK_W-1:0] UP_MIN_TASKS  = 8'd2;
    // x / 100 == (x * ceil(2^35 / 100)) >> 35 for x < 2^30
    localparam logic [PROD_W-1:0] RECIP_100     = 29'd343597384;
    localparam int                RECIP_SHIFT   = 35;
    localparam int                RECIP_PROD_W  = 2 * PROD_W;

    typedef enum logic [3:0] {
        OP_NOP           = 4'd0,
        OP_CLEAR         = 4'd1,
        OP_DISARM        = 4'd2,
        OP_REQ_MAX_STAMP = 4'd3,
        OP_SNAP          = 4'd4,
        OP_DELTAS        = 4'd5,
        OP_LOAD_FULL     = 4'd6,
        OP_LOAD_ZERO     = 4'd7,
        OP_DIV_START     = 4'd8,
        OP_LOAD_Q        = 4'd9,
        OP_MUL_CUR       = 4'd10,
        OP_REQ_DOWN      = 4'd11,
        OP_REQ_MAX       = 4'd12,
        OP_REQ_MIN       = 4'd13,
        OP_EMIT          = 4'd14
    } op_t;

    typedef enum logic [4:0] {
        C_ALWAYS     = 5'd0,
        C_FIRE       = 5'd1,
        C_FUNC_IDLE  = 5'd2,
        C_FUNC_LIMIT = 5'd3,
        C_FUNC_TIMER = 5'd4,
        C_STALE      = 5'd5,
        C_DIDLE_NZ   = 5'd6,
        C_UP_BLOCK   = 5'd7,
        C_TASKS_ZERO = 5'd8,
        C_CUR_MIN    = 5'd9,
        C_DT_LT_MIN  = 5'd10,
        C_DT_ZERO    = 5'd11,
        C_DI_GE_DT   = 5'd12,
        C_DIV_BUSY   = 5'd13,
        C_ARMED      = 5'd14,
        C_ABOVE_MAX  = 5'd15,
        C_BELOW_MIN  = 5'd16,
        C_OUT_FULL   = 5'd17
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic            inv;
        logic [PC_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic fire;
        logic func_idle;
        logic func_limit;
        logic func_timer;
        logic stale;
        logic didle_nz;
        logic up_block;
        logic tasks_zero;
        logic cur_min;
        logic dt_lt_min;
        logic dt_zero;
        logic di_ge_dt;
        logic div_busy;
        logic armed;
        logic above_max;
        logic below_min;
        logic out_full;
    } status_t;

    typedef struct packed {
        logic [CFG_W-1:0]  min_sample;
        logic [FREQ_W-1:0] freq_min;
        logic [FREQ_W-1:0] freq_max;
    } cfg_t;

endpackage

[hw/rtl/load_based_dvfs_governor.sv]
// Top level of the load-based DVFS governor with its APB register port.
`timescale 1ns / 1ps
// One event word in, one result word out. A microcode sequencer steps a small
// datapath; the input is taken only when the sequencer is back at its wait
// step, while a previous result may still sit in the output register. Events
// that skip the load divider (idle exit, limit change, stale sample, ramp-up,
// ramp-down without a division) finish sooner than a ramp-down that divides,
// which waits on the serial load divider that produces one quotient bit per
// cycle. A stalled result adds its stall time once the next result is ready
// to leave.
// Registers: 0x0 min_sample_time_us, 0x4 freq_min_khz, 0x8 freq_max_khz.
module load_based_dvfs_governor
    import lbdg_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // idle_total_us, wall_now_us, runnable_tasks, current_freq_khz
    input  logic [((2*TIME_BITS+30+7)/8)*8-1:0] s_axis_tdata,
    // func
    input  logic [FUNC_W-1:0]                 s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // requested_freq_khz, relation, arm_timer
    output logic [23:0]                       m_axis_tdata,
    // request_valid
    output logic                              m_axis_tuser,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [3:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int T = TIME_BITS;

    cfg_t              cfg_reg;
    status_t           status;
    op_t               op;
    logic              at_wait;
    logic              in_fire;
    logic              cfg_wr;
    logic [1:0]        reg_idx;
    logic              req_valid;
    logic [FREQ_W-1:0] req_freq;
    logic              relation;
    logic              arm;

    assign s_axis_tready = at_wait;
    assign in_fire       = s_axis_tvalid && at_wait;
    assign pready        = 1'b1;
    assign reg_idx       = paddr[3:2];
    assign cfg_wr        = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_sample <= MIN_SAMPLE_RST;
            cfg_reg.freq_min   <= FREQ_MIN_RST;
            cfg_reg.freq_max   <= FREQ_MAX_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_MIN_SAMPLE: cfg_reg.min_sample <= pwdata;
                REG_FREQ_MIN:   cfg_reg.freq_min   <= pwdata[FREQ_W-1:0];
                REG_FREQ_MAX:   cfg_reg.freq_max   <= pwdata[FREQ_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MIN_SAMPLE: prdata = cfg_reg.min_sample;
            REG_FREQ_MIN:   prdata = 32'(cfg_reg.freq_min);
            REG_FREQ_MAX:   prdata = 32'(cfg_reg.freq_max);
            default:        prdata = '0;
        endcase
    end

    lbdg_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .op      (op),
        .at_wait (at_wait)
    );

    lbdg_datapath #(
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .in_func     (s_axis_tuser),
        .in_idle     (s_axis_tdata[T-1:0]),
        .in_wall     (s_axis_tdata[2*T-1:T]),
        .in_tasks    (s_axis_tdata[2*T+TASK_W-1:2*T]),
        .in_cur      (s_axis_tdata[2*T+TASK_W+FREQ_W-1:2*T+TASK_W]),
        .cfg         (cfg_reg),
        .op          (op),
        .status      (status),
        .m_ready     (m_axis_tready),
        .m_valid     (m_axis_tvalid),
        .m_req_valid (req_valid),
        .m_freq      (req_freq),
        .m_relation  (relation),
        .m_arm       (arm)
    );

    assign m_axis_tdata = {arm, relation, req_freq};
    assign m_axis_tuser = req_valid;

endmodule

[hw/rtl/lbdg_div.sv]
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module lbdg_div
    import lbdg_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [TIME_BITS+6:0]   num,
    input  logic [TIME_BITS-1:0]   den,
    output logic                   busy,
    output logic [LOAD_W-1:0]      quot
);

    localparam int NW    = TIME_BITS + 7;
    localparam int CNT_W = $clog2(NW + 1);

    logic [CNT_W-1:0]     cnt_reg;
    logic [TIME_BITS-1:0] rem_reg;
    logic [NW-1:0]        qn_reg;
    logic [TIME_BITS-1:0] den_reg;
    logic [TIME_BITS:0]   trial;
    logic                 fits;
    logic [TIME_BITS:0]   diff;

    assign trial = {rem_reg, qn_reg[NW-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};
    assign busy  = cnt_reg != '0;
    assign quot  = qn_reg[LOAD_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CNT_W'(NW);
        end else if (busy) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            qn_reg  <= num;
            den_reg <= den;
        end else if (busy) begin
            rem_reg <= fits ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
            qn_reg  <= {qn_reg[NW-2:0], fits};
        end
    end

endmodule

[hw/rtl/lbdg_seq.sv]
// Microcode ROM and step counter with conditional jumps.
`timescale 1ns / 1ps
module lbdg_seq
    import lbdg_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  status_t status,
    output op_t     op,
    output logic    at_wait
);

    localparam logic [PC_W-1:0] L_WAIT  = 5'd0;
    localparam logic [PC_W-1:0] L_DOWN  = 5'd8;
    localparam logic [PC_W-1:0] L_DELTA = 5'd10;
    localparam logic [PC_W-1:0] L_DIVW  = 5'd15;
    localparam logic [PC_W-1:0] L_SCALE = 5'd17;
    localparam logic [PC_W-1:0] L_IDLE  = 5'd19;
    localparam logic [PC_W-1:0] L_LIMIT = 5'd21;
    localparam logic [PC_W-1:0] L_BELOW = 5'd23;
    localparam logic [PC_W-1:0] L_EMIT  = 5'd25;

    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t cw;
        cw = '{op: OP_NOP, cond: C_ALWAYS, inv: 1'b1, target: L_WAIT};
        unique case (pc)
            5'd0:  cw = '{op: OP_NOP,           cond: C_FIRE,       inv: 1'b1, target: L_WAIT};
            5'd1:  cw = '{op: OP_CLEAR,         cond: C_FUNC_IDLE,  inv: 1'b0, target: L_IDLE};
            5'd2:  cw = '{op: OP_NOP,           cond: C_FUNC_LIMIT, inv: 1'b0, target: L_LIMIT};
            5'd3:  cw = '{op: OP_NOP,           cond: C_FUNC_TIMER, inv: 1'b1, target: L_EMIT};
            5'd4:  cw = '{op: OP_DISARM,        cond: C_STALE,      inv: 1'b0, target: L_EMIT};
            5'd5:  cw = '{op: OP_NOP,           cond: C_DIDLE_NZ,   inv: 1'b0, target: L_DOWN};
            5'd6:  cw = '{op: OP_NOP,           cond: C_UP_BLOCK,   inv: 1'b0, target: L_EMIT};
            5'd7:  cw = '{op: OP_REQ_MAX_STAMP, cond: C_ALWAYS,     inv: 1'b0, target: L_EMIT};
            5'd8:  cw = '{op: OP_NOP,           cond: C_TASKS_ZERO, inv: 1'b0, target: L_DELTA};
            5'd9:  cw = '{op: OP_SNAP,          cond: C_ALWAYS,     inv: 1'b1, target: L_WAIT};
            5'd10: cw = '{op: OP_DELTAS,        cond: C_CUR_MIN,    inv: 1'b0, target: L_EMIT};
            5'd11: cw = '{op: OP_NOP,           cond: C_DT_LT_MIN,  inv: 1'b0, target: L_EMIT};
            5'd12: cw = '{op: OP_LOAD_FULL,     cond: C_DT_ZERO,    inv: 1'b0, target: L_SCALE};
            5'd13: cw = '{op: OP_LOAD_ZERO,     cond: C_DI_GE_DT,   inv: 1'b0, target: L_SCALE};
            5'd14: cw = '{op: OP_DIV_START,     cond: C_ALWAYS,     inv: 1'b1, target: L_WAIT};
            5'd15: cw = '{op: OP_NOP,           cond: C_DIV_BUSY,   inv: 1'b0, target: L_DIVW};
            5'd16: cw = '{op: OP_LOAD_Q,        cond: C_ALWAYS,     inv: 1'b1, target: L_WAIT};
            5'd17: cw = '{op: OP_MUL_CUR,       cond: C_ALWAYS,     inv: 1'b1, target: L_WAIT};
            5'd18: cw = '{op: OP_REQ_DOWN,      cond: C_ALWAYS,     inv: 1'b0, target: L_EMIT};
            5'd19: cw = '{op: OP_NOP,           cond: C_ARMED,      inv: 1'b0, target: L_EMIT};
            5'd20: cw = '{op: OP_SNAP,          cond: C_ALWAYS,     inv: 1'b0, target: L_EMIT};
            5'd21: cw = '{op: OP_NOP,           cond: C_ABOVE_MAX,  inv: 1'b1, target: L_BELOW};
            5'd22: cw = '{op: OP_REQ_MAX,       cond: C_ALWAYS,     inv: 1'b0, target: L_EMIT};
            5'd23: cw = '{op: OP_NOP,           cond: C_BELOW_MIN,  inv: 1'b1, target: L_EMIT};
            5'd24: cw = '{op: OP_REQ_MIN,       cond: C_ALWAYS,     inv: 1'b1, target: L_WAIT};
            5'd25: cw = '{op: OP_EMIT,          cond: C_OUT_FULL,   inv: 1'b0, target: L_EMIT};
            5'd26: cw = '{op: OP_NOP,           cond: C_ALWAYS,     inv: 1'b0, target: L_WAIT};
            default: cw = '{op: OP_NOP,         cond: C_ALWAYS,     inv: 1'b0, target: L_WAIT};
        endcase
        return cw;
    endfunction

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    ctrl_t           cw;
    logic            flag;

    assign cw      = ucode(pc_reg);
    assign op      = cw.op;
    assign at_wait = pc_reg == L_WAIT;

    always_comb begin
        case (cw.cond)
            C_ALWAYS:     flag = 1'b1;
            C_FIRE:       flag = status.fire;
            C_FUNC_IDLE:  flag = status.func_idle;
            C_FUNC_LIMIT: flag = status.func_limit;
            C_FUNC_TIMER: flag = status.func_timer;
            C_STALE:      flag = status.stale;
            C_DIDLE_NZ:   flag = status.didle_nz;
            C_UP_BLOCK:   flag = status.up_block;
            C_TASKS_ZERO: flag = status.tasks_zero;
            C_CUR_MIN:    flag = status.cur_min;
            C_DT_LT_MIN:  flag = status.dt_lt_min;
            C_DT_ZERO:    flag = status.dt_zero;
            C_DI_GE_DT:   flag = status.di_ge_dt;
            C_DIV_BUSY:   flag = status.div_busy;
            C_ARMED:      flag = status.armed;
            C_ABOVE_MAX:  flag = status.above_max;
            C_BELOW_MIN:  flag = status.below_min;
            C_OUT_FULL:   flag = status.out_full;
            default:      flag = 1'b0;
        endcase
        pc_next = (flag ^ cw.inv) ? cw.target : pc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= L_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

[hw/rtl/lbdg_datapath.sv]
// Governor datapath: event registers, time stamps, load math and result register.
`timescale 1ns / 1ps
module lbdg_datapath
    import lbdg_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_fire,
    input  logic [FUNC_W-1:0]    in_func,
    input  logic [TIME_BITS-1:0] in_idle,
    input  logic [TIME_BITS-1:0] in_wall,
    input  logic [TASK_W-1:0]    in_tasks,
    input  logic [FREQ_W-1:0]    in_cur,
    input  cfg_t                 cfg,
    input  op_t                  op,
    output status_t              status,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic                 m_req_valid,
    output logic [FREQ_W-1:0]    m_freq,
    output logic                 m_relation,
    output logic                 m_arm
);

    localparam int NW = TIME_BITS + 7;
    localparam int CW = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

    logic [FUNC_W-1:0]    func_reg;
    logic [TIME_BITS-1:0] idle_reg;
    logic [TIME_BITS-1:0] wall_reg;
    logic [TASK_W-1:0]    tasks_reg;
    logic [FREQ_W-1:0]    cur_reg;

    logic [TIME_BITS-1:0] snap_reg;
    logic [TIME_BITS-1:0] exit_stamp_reg;
    logic [TIME_BITS-1:0] chg_wall_reg;
    logic [TIME_BITS-1:0] chg_idle_reg;
    logic                 armed_reg;

    logic [TIME_BITS-1:0] dt_reg;
    logic [TIME_BITS-1:0] di_reg;
    logic [LOAD_W-1:0]    load_reg;
    logic [PROD_W-1:0]    prod_reg;

    logic                 res_valid_reg;
    logic [FREQ_W-1:0]    res_freq_reg;
    logic                 res_rel_reg;
    logic                 res_arm_reg;

    logic                 m_valid_reg;
    logic                 m_req_reg;
    logic [FREQ_W-1:0]    m_freq_reg;
    logic                 m_rel_reg;
    logic                 m_arm_reg;

    logic [TIME_BITS-1:0]    busy_diff;
    logic [NW-1:0]           div_num;
    logic                    div_busy;
    logic [LOAD_W-1:0]       div_quot;
    logic [RECIP_PROD_W-1:0] recip_prod;
    logic                    out_full;
    logic                    emit;

    assign busy_diff  = dt_reg - di_reg;
    assign div_num    = {1'b0, busy_diff, 6'b0} + {2'b0, busy_diff, 5'b0}
                      + {5'b0, busy_diff, 2'b0};
    assign recip_prod = RECIP_PROD_W'(prod_reg) * RECIP_PROD_W'(RECIP_100);
    assign out_full   = m_valid_reg && !m_ready;
    assign emit       = (op == OP_EMIT) && !out_full;

    lbdg_div #(
        .TIME_BITS (TIME_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (op == OP_DIV_START),
        .num     (div_num),
        .den     (dt_reg),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    always_comb begin
        status.fire       = in_fire;
        status.func_idle  = func_reg == FUNC_IDLE_EXIT;
        status.func_limit = func_reg == FUNC_LIMITS;
        status.func_timer = func_reg == FUNC_SAMPLE;
        status.stale      = wall_reg == exit_stamp_reg;
        status.didle_nz   = idle_reg != snap_reg;
        status.up_block   = (cur_reg == cfg.freq_max) || (tasks_reg < UP_MIN_TASKS);
        status.tasks_zero = tasks_reg == '0;
        status.cur_min    = cur_reg == cfg.freq_min;
        status.dt_lt_min  = CW'(dt_reg) < CW'(cfg.min_sample);
        status.dt_zero    = dt_reg == '0;
        status.di_ge_dt   = di_reg >= dt_reg;
        status.div_busy   = div_busy;
        status.armed      = armed_reg;
        status.above_max  = cfg.freq_max < cur_reg;
        status.below_min  = cfg.freq_min > cur_reg;
        status.out_full   = out_full;
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            func_reg  <= in_func;
            idle_reg  <= in_idle;
            wall_reg  <= in_wall;
            tasks_reg <= in_tasks;
            cur_reg   <= in_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_reg       <= '0;
            exit_stamp_reg <= '0;
            chg_wall_reg   <= '0;
            chg_idle_reg   <= '0;
            armed_reg      <= 1'b0;
        end else begin
            case (op)
                OP_DISARM: armed_reg <= 1'b0;
                OP_SNAP: begin
                    snap_reg       <= idle_reg;
                    exit_stamp_reg <= wall_reg;
                    armed_reg      <= 1'b1;
                end
                OP_REQ_MAX_STAMP, OP_REQ_DOWN: begin
                    chg_wall_reg <= wall_reg;
                    chg_idle_reg <= idle_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (op)
            OP_CLEAR: begin
                res_valid_reg <= 1'b0;
                res_freq_reg  <= '0;
                res_rel_reg   <= 1'b0;
                res_arm_reg   <= 1'b0;
            end
            OP_SNAP:      res_arm_reg <= 1'b1;
            OP_DELTAS: begin
                dt_reg <= wall_reg - chg_wall_reg;
                di_reg <= idle_reg - chg_idle_reg;
            end
            OP_LOAD_FULL: load_reg <= LOAD_FULL;
            OP_LOAD_ZERO: load_reg <= '0;
            OP_LOAD_Q:    load_reg <= div_quot;
            OP_MUL_CUR:   prod_reg <= PROD_W'(cur_reg) * PROD_W'(load_reg);
            OP_REQ_DOWN: begin
                res_valid_reg <= 1'b1;
                res_freq_reg  <= recip_prod[RECIP_SHIFT +: FREQ_W];
                res_rel_reg   <= 1'b0;
            end
            OP_REQ_MAX_STAMP, OP_REQ_MAX: begin
                res_valid_reg <= 1'b1;
                res_freq_reg  <= cfg.freq_max;
                res_rel_reg   <= 1'b1;
            end
            OP_REQ_MIN: begin
                res_valid_reg <= 1'b1;
                res_freq_reg  <= cfg.freq_min;
                res_rel_reg   <= 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_req_reg  <= res_valid_reg;
            m_freq_reg <= res_freq_reg;
            m_rel_reg  <= res_rel_reg;
            m_arm_reg  <= res_arm_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_req_valid = m_req_reg;
    assign m_freq      = m_freq_reg;
    assign m_relation  = m_rel_reg;
    assign m_arm       = m_arm_reg;

endmodule

[hw/rtl/lbdg_checker.sv]
// Port-level assertions for the governor, bound to the top level.
`timescale 1ns / 1ps
module lbdg_port_checks (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    a_no_req_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[22:0] == 23'd0)
        else $error("frequency or relation set without a request");

    a_arm_no_up: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[23] |-> !(m_axis_tuser && m_axis_tdata[22]))
        else $error("timer armed together with a ramp to max");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word taken before the first was processed");

endmodule

bind load_based_dvfs_governor lbdg_port_checks u_lbdg_port_checks (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
